// ===== sv/hbw_pkg.sv =====
// ---------------------------------------------------------------------------
// hbw_pkg
// Shared constants, types and helpers for the perspective warp datapath.
// ---------------------------------------------------------------------------
package hbw_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int CHANNELS   = 3;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 32;
   localparam int COORD_W    = 12;
   localparam int SIZE_W     = 9;
   localparam int LOAD_XY_W  = 8;
   localparam int CH_W       = 2;
   localparam int COEF_IDX_W = 4;
   localparam int NCOEF      = 9;

   localparam int PROD_W  = COEF_W + COORD_W + 1;
   localparam int NUM_W   = PROD_W + 2;
   localparam int MAG_W   = NUM_W;
   localparam int FRAC_W  = 16;
   localparam int FLOOR_W = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
   localparam int Q_W     = FLOOR_W + FRAC_W;
   localparam int REM_W   = MAG_W + Q_W;

   localparam int HROW_W     = $clog2(MAX_HEIGHT) - 1;
   localparam int HCOL_W     = $clog2(MAX_WIDTH) - 1;
   localparam int BANK_AW    = CH_W + HROW_W + HCOL_W;
   localparam int BANK_DEPTH = CHANNELS * (MAX_HEIGHT / 2) * (MAX_WIDTH / 2);

   localparam int WGT_W  = FRAC_W + 2;
   localparam int LERP_W = SAMPLE_W + WGT_W;
   localparam int V_W    = LERP_W + WGT_W;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_COEF   = 2'd1;
   localparam logic [1:0] OP_WARP   = 2'd2;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]           op;
      logic [LOAD_XY_W-1:0] lx;
      logic [LOAD_XY_W-1:0] ly;
      logic [CH_W-1:0]      lch;
      logic [SAMPLE_W-1:0]  lsample;
   } item_side_type;

   typedef struct packed {
      logic             vld;
      item_side_type    side;
      logic             ok;
      logic [MAG_W-1:0] nx;
      logic [MAG_W-1:0] ny;
      logic [MAG_W-1:0] dz;
   } div_req_type;

   typedef struct packed {
      logic           vld;
      item_side_type  side;
      logic           ok;
      logic [Q_W-1:0] qx;
      logic [Q_W-1:0] qy;
   } div_rsp_type;

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [NUM_W-1:0] v);
      logic signed [NUM_W-1:0] n;
      n = -v;
      return v[NUM_W-1] ? MAG_W'(n) : MAG_W'(v);
   endfunction

endpackage

// ===== sv/homography_bilinear_warp.sv =====
// ---------------------------------------------------------------------------
// homography_bilinear_warp
// Inverse perspective warp with bilinear sampling of a banked source image.
// ---------------------------------------------------------------------------
// The channel sequencer reads the four parity banks once per channel, so a warp
// request holds the front end until its last channel is issued; load requests
// are taken one per cycle while the sequencer is free and the output is not
// stalled. Reset clears valid bits and sets both image sizes to 256; sample
// memory and coefficients hold garbage until written.
module homography_bilinear_warp
   import hbw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // load_x, load_y, load_channel, load_sample, coef_index, coef_value,
   // out_x, out_y, 2 bits zero pad
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // warped_sample
   output logic [2:0]  rsp_tuser,   // channel, in_range
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   // request fields
   logic [LOAD_XY_W-1:0]  f_lx, f_ly;
   logic [CH_W-1:0]       f_lch;
   logic [SAMPLE_W-1:0]   f_ls;
   logic [COEF_IDX_W-1:0] f_cidx;
   logic [COEF_W-1:0]     f_cval;
   logic [COORD_W-1:0]    f_ox, f_oy;
   logic                  accept;

   assign f_lx   = req_tdata[7:0];
   assign f_ly   = req_tdata[15:8];
   assign f_lch  = req_tdata[17:16];
   assign f_ls   = req_tdata[33:18];
   assign f_cidx = req_tdata[37:34];
   assign f_cval = req_tdata[69:38];
   assign f_ox   = req_tdata[81:70];
   assign f_oy   = req_tdata[93:82];

   logic en, front_en, take, seq_last;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = front_en;
   assign csr_ready  = 1'b1;

   // config
   logic [SIZE_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(MAX_WIDTH);
         height_ff <= SIZE_W'(MAX_HEIGHT);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // coefficients, written at acceptance
   logic [COEF_W-1:0] coef_ff [0:NCOEF-1];

   always_ff @(posedge clock) begin
      if (accept && req_tuser == OP_COEF && f_cidx < COEF_IDX_W'(NCOEF)) begin
         coef_ff[f_cidx] <= f_cval;
      end
   end

   // S1: products
   logic                     s1_v_ff;
   item_side_type            s1_side_ff;
   logic signed [PROD_W-1:0] s1_p0_ff, s1_p1_ff, s1_p3_ff, s1_p4_ff, s1_p6_ff, s1_p7_ff;
   logic signed [COEF_W-1:0] s1_c2_ff, s1_c5_ff, s1_c8_ff;
   logic signed [COORD_W:0]  sox, soy;

   assign sox = $signed({1'b0, f_ox});
   assign soy = $signed({1'b0, f_oy});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (front_en) begin
         s1_v_ff <= accept && (req_tuser == OP_SAMPLE || req_tuser == OP_WARP);
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s1_side_ff <= '{op: req_tuser, lx: f_lx, ly: f_ly, lch: f_lch, lsample: f_ls};
         s1_p0_ff   <= $signed(coef_ff[0]) * sox;
         s1_p1_ff   <= $signed(coef_ff[1]) * soy;
         s1_p3_ff   <= $signed(coef_ff[3]) * sox;
         s1_p4_ff   <= $signed(coef_ff[4]) * soy;
         s1_p6_ff   <= $signed(coef_ff[6]) * sox;
         s1_p7_ff   <= $signed(coef_ff[7]) * soy;
         s1_c2_ff   <= $signed(coef_ff[2]);
         s1_c5_ff   <= $signed(coef_ff[5]);
         s1_c8_ff   <= $signed(coef_ff[8]);
      end
   end

   // S2: sums
   logic                    s2_v_ff;
   item_side_type           s2_side_ff;
   logic signed [NUM_W-1:0] s2_xn_ff, s2_yn_ff, s2_zn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (front_en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s2_side_ff <= s1_side_ff;
         s2_xn_ff   <= NUM_W'(s1_p0_ff) + NUM_W'(s1_p1_ff) + NUM_W'(s1_c2_ff);
         s2_yn_ff   <= NUM_W'(s1_p3_ff) + NUM_W'(s1_p4_ff) + NUM_W'(s1_c5_ff);
         s2_zn_ff   <= NUM_W'(s1_p6_ff) + NUM_W'(s1_p7_ff) + NUM_W'(s1_c8_ff);
      end
   end

   // S3: magnitudes and sign checks
   logic             s3_v_ff, s3_ok_ff;
   item_side_type    s3_side_ff;
   logic [MAG_W-1:0] s3_nx_ff, s3_ny_ff, s3_dz_ff;
   logic             s3_ok_in;

   assign s3_ok_in = (s2_zn_ff != '0)
                     && (s2_xn_ff == '0 || s2_xn_ff[NUM_W-1] == s2_zn_ff[NUM_W-1])
                     && (s2_yn_ff == '0 || s2_yn_ff[NUM_W-1] == s2_zn_ff[NUM_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (front_en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s3_side_ff <= s2_side_ff;
         s3_ok_ff   <= s3_ok_in;
         s3_nx_ff   <= mag_of(s2_xn_ff);
         s3_ny_ff   <= mag_of(s2_yn_ff);
         s3_dz_ff   <= mag_of(s2_zn_ff);
      end
   end

   // S4: quotient overflow check, divider request
   div_req_type div_req_ff;
   div_rsp_type div_rsp;
   logic        ovfx, ovfy;

   assign ovfx = (MAG_W + FLOOR_W)'(s3_nx_ff) >= {s3_dz_ff, FLOOR_W'(0)};
   assign ovfy = (MAG_W + FLOOR_W)'(s3_ny_ff) >= {s3_dz_ff, FLOOR_W'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_req_ff.vld <= 1'b0;
      end else if (front_en) begin
         div_req_ff.vld <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         div_req_ff.side <= s3_side_ff;
         div_req_ff.ok   <= s3_ok_ff && !ovfx && !ovfy;
         div_req_ff.nx   <= s3_nx_ff;
         div_req_ff.ny   <= s3_ny_ff;
         div_req_ff.dz   <= s3_dz_ff;
      end
   end

   hbw_proj u_proj (
      .clock (clock),
      .reset (reset),
      .en    (front_en),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   // range check
   logic                rg_v_ff, rg_ok_ff;
   item_side_type       rg_side_ff;
   logic [FLOOR_W-1:0]  rg_x0_ff, rg_y0_ff;
   logic [FRAC_W-1:0]   rg_fx_ff, rg_fy_ff;
   logic [SIZE_W-1:0]   w_eff, h_eff;
   logic [FLOOR_W-1:0]  q_x0, q_y0;
   logic                rg_ok_in;

   assign w_eff    = (width_ff > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_ff;
   assign h_eff    = (height_ff > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_ff;
   assign q_x0     = div_rsp.qx[Q_W-1:FRAC_W];
   assign q_y0     = div_rsp.qy[Q_W-1:FRAC_W];
   assign rg_ok_in = div_rsp.ok && w_eff >= SIZE_W'(2) && h_eff >= SIZE_W'(2)
                     && SIZE_W'(q_x0) <= w_eff - SIZE_W'(2)
                     && SIZE_W'(q_y0) <= h_eff - SIZE_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         rg_v_ff <= 1'b0;
      end else if (front_en) begin
         rg_v_ff <= div_rsp.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         rg_side_ff <= div_rsp.side;
         rg_ok_ff   <= rg_ok_in;
         rg_x0_ff   <= q_x0;
         rg_y0_ff   <= q_y0;
         rg_fx_ff   <= div_rsp.qx[FRAC_W-1:0];
         rg_fy_ff   <= div_rsp.qy[FRAC_W-1:0];
      end
   end

   // channel sequencer
   logic               seq_v_ff, seq_ok_ff;
   item_side_type      seq_side_ff;
   logic [FLOOR_W-1:0] seq_x0_ff, seq_y0_ff;
   logic [FRAC_W-1:0]  seq_fx_ff, seq_fy_ff;
   logic [CH_W-1:0]    seq_ch_ff;
   logic               seq_warp;

   assign seq_warp = seq_v_ff && seq_side_ff.op == OP_WARP;
   assign seq_last = seq_v_ff && (!seq_warp || seq_ch_ff == CH_W'(CHANNELS - 1));
   assign take     = !seq_v_ff || seq_last;
   assign front_en = en && take;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_v_ff  <= 1'b0;
         seq_ch_ff <= '0;
      end else if (en) begin
         if (take) begin
            seq_v_ff  <= rg_v_ff;
            seq_ch_ff <= '0;
         end else begin
            seq_ch_ff <= seq_ch_ff + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         seq_side_ff <= rg_side_ff;
         seq_ok_ff   <= rg_ok_ff;
         seq_x0_ff   <= rg_x0_ff;
         seq_y0_ff   <= rg_y0_ff;
         seq_fx_ff   <= rg_fx_ff;
         seq_fy_ff   <= rg_fy_ff;
      end
   end

   // source image: four banks by row and column parity
   logic [FLOOR_W:0]      x0p1, y0p1;
   logic [BANK_AW-1:0]    waddr;
   logic                  wr_en, rd_en;
   logic [SAMPLE_W-1:0]   rd_ff [0:3];

   assign x0p1  = {1'b0, seq_x0_ff} + (FLOOR_W + 1)'(1);
   assign y0p1  = {1'b0, seq_y0_ff} + (FLOOR_W + 1)'(1);
   assign waddr = {seq_side_ff.lch, seq_side_ff.ly[HROW_W:1], seq_side_ff.lx[HCOL_W:1]};
   assign wr_en = en && seq_v_ff && seq_side_ff.op == OP_SAMPLE
                  && seq_side_ff.lch < CH_W'(CHANNELS);
   assign rd_en = en && seq_warp;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic YP = b[1];
      localparam logic XP = b[0];
      logic [SAMPLE_W-1:0] mem [0:BANK_DEPTH-1];
      logic [HROW_W-1:0]   row;
      logic [HCOL_W-1:0]   col;
      logic                we;

      assign row = YP ? seq_y0_ff[HROW_W:1] : y0p1[HROW_W:1];
      assign col = XP ? seq_x0_ff[HCOL_W:1] : x0p1[HCOL_W:1];
      assign we  = wr_en && seq_side_ff.ly[0] == YP && seq_side_ff.lx[0] == XP;

      always_ff @(posedge clock) begin
         if (we) begin
            mem[waddr] <= seq_side_ff.lsample;
         end
         if (rd_en) begin
            rd_ff[b] <= mem[{seq_ch_ff, row, col}];
         end
      end
   end

   // R: read data stage
   logic              r_v_ff, r_ok_ff, r_xp_ff, r_yp_ff;
   logic [CH_W-1:0]   r_ch_ff;
   logic [FRAC_W-1:0] r_fx_ff, r_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (en) begin
         r_v_ff <= seq_warp;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ok_ff <= seq_ok_ff;
         r_xp_ff <= seq_x0_ff[0];
         r_yp_ff <= seq_y0_ff[0];
         r_ch_ff <= seq_ch_ff;
         r_fx_ff <= seq_fx_ff;
         r_fy_ff <= seq_fy_ff;
      end
   end

   // M1: horizontal products
   logic [SAMPLE_W-1:0]      tl, tr, bl, br;
   logic signed [WGT_W-1:0]  wx0, wx1;
   logic                     m1_v_ff, m1_ok_ff;
   logic [CH_W-1:0]          m1_ch_ff;
   logic [FRAC_W-1:0]        m1_fy_ff;
   logic signed [LERP_W-1:0] m1_ta_ff, m1_tb_ff, m1_ba_ff, m1_bb_ff;

   assign tl  = r_yp_ff ? (r_xp_ff ? rd_ff[3] : rd_ff[2]) : (r_xp_ff ? rd_ff[1] : rd_ff[0]);
   assign tr  = r_yp_ff ? (r_xp_ff ? rd_ff[2] : rd_ff[3]) : (r_xp_ff ? rd_ff[0] : rd_ff[1]);
   assign bl  = r_yp_ff ? (r_xp_ff ? rd_ff[1] : rd_ff[0]) : (r_xp_ff ? rd_ff[3] : rd_ff[2]);
   assign br  = r_yp_ff ? (r_xp_ff ? rd_ff[0] : rd_ff[1]) : (r_xp_ff ? rd_ff[2] : rd_ff[3]);
   assign wx1 = $signed(WGT_W'(r_fx_ff));
   assign wx0 = $signed(WGT_W'(1 << FRAC_W) - WGT_W'(r_fx_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff <= r_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ok_ff <= r_ok_ff;
         m1_ch_ff <= r_ch_ff;
         m1_fy_ff <= r_fy_ff;
         m1_ta_ff <= $signed(tl) * wx0;
         m1_tb_ff <= $signed(tr) * wx1;
         m1_ba_ff <= $signed(bl) * wx0;
         m1_bb_ff <= $signed(br) * wx1;
      end
   end

   // M2: row sums
   logic                     m2_v_ff, m2_ok_ff;
   logic [CH_W-1:0]          m2_ch_ff;
   logic [FRAC_W-1:0]        m2_fy_ff;
   logic signed [LERP_W-1:0] m2_top_ff, m2_bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_v_ff <= 1'b0;
      end else if (en) begin
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ok_ff  <= m1_ok_ff;
         m2_ch_ff  <= m1_ch_ff;
         m2_fy_ff  <= m1_fy_ff;
         m2_top_ff <= m1_ta_ff + m1_tb_ff;
         m2_bot_ff <= m1_ba_ff + m1_bb_ff;
      end
   end

   // M3: vertical products
   logic signed [WGT_W-1:0] wy0, wy1;
   logic                    m3_v_ff, m3_ok_ff;
   logic [CH_W-1:0]         m3_ch_ff;
   logic signed [V_W-1:0]   m3_vt_ff, m3_vb_ff;

   assign wy1 = $signed(WGT_W'(m2_fy_ff));
   assign wy0 = $signed(WGT_W'(1 << FRAC_W) - WGT_W'(m2_fy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_v_ff <= 1'b0;
      end else if (en) begin
         m3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_ok_ff <= m2_ok_ff;
         m3_ch_ff <= m2_ch_ff;
         m3_vt_ff <= m2_top_ff * wy0;
         m3_vb_ff <= m2_bot_ff * wy1;
      end
   end

   // M4: final sum with rounding offset
   logic                  m4_v_ff, m4_ok_ff;
   logic [CH_W-1:0]       m4_ch_ff;
   logic signed [V_W-1:0] m4_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m4_v_ff <= 1'b0;
      end else if (en) begin
         m4_v_ff <= m3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m4_ok_ff  <= m3_ok_ff;
         m4_ch_ff  <= m3_ch_ff;
         m4_sum_ff <= m3_vt_ff + m3_vb_ff + $signed(V_W'(1) << (2 * FRAC_W - 1));
      end
   end

   // output register
   logic signed [V_W-1:0]         rsh;
   logic [V_W-SAMPLE_W:0]         hi;
   logic [SAMPLE_W-1:0]           val_in;
   logic                          o_v_ff, o_ok_ff, o_last_ff;
   logic [CH_W-1:0]               o_ch_ff;
   logic [SAMPLE_W-1:0]           o_data_ff;

   assign rsh = m4_sum_ff >>> (2 * FRAC_W);
   assign hi  = rsh[V_W-1:SAMPLE_W-1];

   always_comb begin
      if (!m4_ok_ff) begin
         val_in = '0;
      end else if (hi == '0 || hi == '1) begin
         val_in = rsh[SAMPLE_W-1:0];
      end else begin
         val_in = rsh[V_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : {1'b0, {(SAMPLE_W - 1){1'b1}}};
      end
   end

   assign en = !o_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en) begin
         o_v_ff <= m4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_ok_ff   <= m4_ok_ff;
         o_ch_ff   <= m4_ch_ff;
         o_last_ff <= m4_ch_ff == CH_W'(CHANNELS - 1);
         o_data_ff <= val_in;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = {o_ok_ff, o_ch_ff};
   assign rsp_tlast  = o_last_ff;

endmodule

// ===== sv/hbw_proj.sv =====
// ---------------------------------------------------------------------------
// hbw_proj
// Pipelined restoring divider pair: x/z and y/z, one quotient bit per stage.
// ---------------------------------------------------------------------------
module hbw_proj
   import hbw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic             vld_ff  [0:Q_W-1];
   item_side_type    side_ff [0:Q_W-1];
   logic             ok_ff   [0:Q_W-1];
   logic [MAG_W-1:0] den_ff  [0:Q_W-1];
   logic [REM_W-1:0] remx_ff [0:Q_W-1];
   logic [REM_W-1:0] remy_ff [0:Q_W-1];
   logic [Q_W-1:0]   qx_ff   [0:Q_W-1];
   logic [Q_W-1:0]   qy_ff   [0:Q_W-1];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int SH = Q_W - 1 - s;
      logic             vld_p;
      item_side_type    side_p;
      logic             ok_p;
      logic [MAG_W-1:0] den_p;
      logic [REM_W-1:0] remx_p, remy_p, dsh, remx_in, remy_in;
      logic [Q_W-1:0]   qx_p, qy_p, qx_in, qy_in;
      logic             gex, gey;

      if (s == 0) begin : g_first
         assign vld_p  = req.vld;
         assign side_p = req.side;
         assign ok_p   = req.ok;
         assign den_p  = req.dz;
         assign remx_p = REM_W'({req.nx, FRAC_W'(0)});
         assign remy_p = REM_W'({req.ny, FRAC_W'(0)});
         assign qx_p   = '0;
         assign qy_p   = '0;
      end else begin : g_next
         assign vld_p  = vld_ff[s-1];
         assign side_p = side_ff[s-1];
         assign ok_p   = ok_ff[s-1];
         assign den_p  = den_ff[s-1];
         assign remx_p = remx_ff[s-1];
         assign remy_p = remy_ff[s-1];
         assign qx_p   = qx_ff[s-1];
         assign qy_p   = qy_ff[s-1];
      end

      assign dsh     = REM_W'(den_p) << SH;
      assign gex     = remx_p >= dsh;
      assign gey     = remy_p >= dsh;
      assign remx_in = gex ? remx_p - dsh : remx_p;
      assign remy_in = gey ? remy_p - dsh : remy_p;
      assign qx_in   = {qx_p[Q_W-2:0], gex};
      assign qy_in   = {qy_p[Q_W-2:0], gey};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= side_p;
            ok_ff[s]   <= ok_p;
            den_ff[s]  <= den_p;
            remx_ff[s] <= remx_in;
            remy_ff[s] <= remy_in;
            qx_ff[s]   <= qx_in;
            qy_ff[s]   <= qy_in;
         end
      end
   end

   assign rsp.vld  = vld_ff[Q_W-1];
   assign rsp.side = side_ff[Q_W-1];
   assign rsp.ok   = ok_ff[Q_W-1];
   assign rsp.qx   = qx_ff[Q_W-1];
   assign rsp.qy   = qy_ff[Q_W-1];

endmodule

// ===== sv/hbw_check.sv =====
// ---------------------------------------------------------------------------
// hbw_check
// Port-level checks for the warp block, bound to the top level.
// ---------------------------------------------------------------------------
module hbw_check
   import hbw_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [95:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        csr_index,
   input logic [8:0]  csr_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata == '0)
      else $error("out of range sample not zero");

   a_last_ch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tuser[1:0] == CH_W'(CHANNELS - 1)))
      else $error("last marker on wrong channel");

endmodule

bind homography_bilinear_warp hbw_check u_hbw_check (.*);

// ===== test/homography_bilinear_warp_test.sv =====
// ---------------------------------------------------------------------------
// homography_bilinear_warp_test
// Self-checking bench for the perspective warp. A short directed table covers
// zero divisors, points outside the source, ignored loads and extreme values.
// Random phases follow, each with its own image size and homography and one of
// three idling mixes. Every warp's per-channel results are predicted here and
// compared in order. Source samples are loaded on demand, so no unwritten entry is read.
// ---------------------------------------------------------------------------
module homography_bilinear_warp_test;
   import hbw_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IMG_DEPTH = CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [1:0]  pad;
      logic [11:0] oy;
      logic [11:0] ox;
      logic [31:0] cv;
      logic [3:0]  ci;
      logic [15:0] ls;
      logic [1:0]  lch;
      logic [7:0]  ly;
      logic [7:0]  lx;
   } req_fields_t;

   typedef struct packed {
      logic [1:0]  op;
      req_fields_t f;
   } warp_req_t;

   typedef struct packed {
      logic [1:0]  ch;
      logic [15:0] smp;
      logic        rng;
      logic        last;
   } warp_rsp_t;

   typedef struct packed {
      logic        typed;
      logic [15:0] smp;
      logic        rng;
   } typed_rsp_t;

   typedef struct {
      warp_req_t  req;
      typed_rsp_t exp;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [8:0]  csr_data = '0;

   homography_bilinear_warp i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // predictor state, updated on accepted requests and size writes
   logic signed [15:0] pixel_mem [IMG_DEPTH];
   logic [8:0][31:0]   coef_reg;
   logic [8:0]         width_reg = 9'd256;
   logic [8:0]         height_reg = 9'd256;
   // stimulus planning state, updated when a request is queued
   bit                 pixel_loaded [IMG_DEPTH];
   logic [8:0][31:0]   coef_plan;

   warp_rsp_t  expect_q [$];
   typed_rsp_t typed_q [$];
   int         errors = 0;
   int         tx_idle_pct = 0;
   int         rx_idle_pct = 0;
   int         hold_cycles = 0;
   int         stall_count = 0;

   function automatic logic project(input longint num, input longint zd,
                                    output logic [63:0] q);
      logic [63:0] a, d;
      q = '0;
      a = (num < 0 ? 64'(-num) : 64'(num)) << 16;
      if (zd == 0) return 1'b0;
      if (num != 0 && ((num < 0) != (zd < 0))) return 1'b0;
      d = zd < 0 ? 64'(-zd) : 64'(zd);
      q = a / d;
      return 1'b1;
   endfunction

   function automatic logic map_point(input logic [8:0][31:0] k,
                                      input logic [8:0] wr, input logic [8:0] hr,
                                      input logic [11:0] ox, input logic [11:0] oy,
                                      output logic [63:0] qx, output logic [63:0] qy);
      longint xn, yn, zn, w, h;
      logic   ok;
      xn = longint'($signed(k[0])) * longint'(ox) + longint'($signed(k[1])) * longint'(oy)
           + longint'($signed(k[2]));
      yn = longint'($signed(k[3])) * longint'(ox) + longint'($signed(k[4])) * longint'(oy)
           + longint'($signed(k[5]));
      zn = longint'($signed(k[6])) * longint'(ox) + longint'($signed(k[7])) * longint'(oy)
           + longint'($signed(k[8]));
      w = wr > MAX_WIDTH ? MAX_WIDTH : longint'(wr);
      h = hr > MAX_HEIGHT ? MAX_HEIGHT : longint'(hr);
      qy = '0;
      ok = project(xn, zn, qx);
      if (ok) ok = project(yn, zn, qy);
      if (ok) ok = w >= 2 && h >= 2 && (qx >> 16) <= 64'(w - 2) && (qy >> 16) <= 64'(h - 2);
      return ok;
   endfunction

   function automatic int pixel_index(input int c, input longint y, input longint x);
      return (c * MAX_HEIGHT + int'(y)) * MAX_WIDTH + int'(x);
   endfunction

   task automatic predict_warp(input logic [11:0] ox, input logic [11:0] oy);
      logic [63:0] qx, qy;
      logic        ok;
      longint      x0, y0, fx, fy, top, bot, v, val;
      ok = map_point(coef_reg, width_reg, height_reg, ox, oy, qx, qy);
      x0 = longint'(qx >> 16);
      y0 = longint'(qy >> 16);
      fx = longint'(qx[15:0]);
      fy = longint'(qy[15:0]);
      for (int c = 0; c < CHANNELS; c++) begin
         val = 0;
         if (ok) begin
            top = longint'(pixel_mem[pixel_index(c, y0, x0)]) * (65536 - fx)
                + longint'(pixel_mem[pixel_index(c, y0, x0 + 1)]) * fx;
            bot = longint'(pixel_mem[pixel_index(c, y0 + 1, x0)]) * (65536 - fx)
                + longint'(pixel_mem[pixel_index(c, y0 + 1, x0 + 1)]) * fx;
            v = top * (65536 - fy) + bot * fy;
            val = ((v + (64'sd1 <<< 31) + (64'sd1 <<< 48)) >> 32) - 65536;
            if (val > 32767) val = 32767;
            if (val < -32768) val = -32768;
         end
         expect_q.push_back('{ch: 2'(c), smp: val[15:0], rng: ok,
                              last: (c == CHANNELS - 1)});
      end
   endtask

   // accepted requests: update the predictor and queue expected results
   always @(posedge clock) begin
      warp_req_t  r;
      typed_rsp_t t;
      if (!reset && req_tvalid && req_tready) begin
         r.op = req_tuser;
         r.f = req_tdata;
         t = typed_q.pop_front();
         case (r.op)
            OP_SAMPLE: begin
               if (r.f.lch < CHANNELS)
                  pixel_mem[pixel_index(r.f.lch, r.f.ly, r.f.lx)] = r.f.ls;
            end
            OP_COEF: begin
               if (r.f.ci < NCOEF) coef_reg[r.f.ci] = r.f.cv;
            end
            OP_WARP: begin
               if (t.typed) begin
                  for (int c = 0; c < CHANNELS; c++)
                     expect_q.push_back('{ch: 2'(c), smp: t.smp, rng: t.rng,
                                          last: (c == CHANNELS - 1)});
               end else begin
                  predict_warp(r.f.ox, r.f.oy);
               end
            end
            default: ;
         endcase
      end
   end

   task automatic report(input string what, input warp_rsp_t e, input warp_rsp_t a);
      errors++;
      if (errors <= 10)
         $display({"mismatch %s: expected ch %0d smp %0d rng %0d last %0d,",
                   " got ch %0d smp %0d rng %0d last %0d"},
                  what, e.ch, $signed(e.smp), e.rng, e.last,
                  a.ch, $signed(a.smp), a.rng, a.last);
   endtask

   always @(posedge clock) begin
      warp_rsp_t a, e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = '{ch: rsp_tuser[1:0], smp: rsp_tdata, rng: rsp_tuser[2], last: rsp_tlast};
         if (expect_q.size() == 0) begin
            report("unexpected result", '0, a);
         end else begin
            e = expect_q.pop_front();
            if (a != e) report("result", e, a);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("homography_bilinear_warp_test failed");
         $finish;
      end
   end

   // result side: random stalls plus an optional long hold-off
   initial begin
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge clock);
         end
      end
   end

   task automatic push_req(input warp_req_t r, input typed_rsp_t t);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      if (r.op == OP_SAMPLE && r.f.lch < CHANNELS)
         pixel_loaded[pixel_index(r.f.lch, r.f.ly, r.f.lx)] = 1'b1;
      if (r.op == OP_COEF && r.f.ci < NCOEF) coef_plan[r.f.ci] = r.f.cv;
      typed_q.push_back(t);
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= r.f;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic warp_req_t mk_sample(input logic [7:0] x, input logic [7:0] y,
                                           input logic [1:0] c, input logic [15:0] s);
      warp_req_t r;
      r = '0;
      r.op = OP_SAMPLE;
      r.f.lx = x; r.f.ly = y; r.f.lch = c; r.f.ls = s;
      return r;
   endfunction

   function automatic warp_req_t mk_coef(input logic [3:0] i, input logic [31:0] v);
      warp_req_t r;
      r = '0;
      r.op = OP_COEF;
      r.f.ci = i; r.f.cv = v;
      return r;
   endfunction

   function automatic warp_req_t mk_warp(input logic [11:0] x, input logic [11:0] y);
      warp_req_t r;
      r = '0;
      r.op = OP_WARP;
      r.f.ox = x; r.f.oy = y;
      return r;
   endfunction

   // a warp that will sample the source first loads any corner not yet written
   task automatic send_item(input warp_req_t r, input typed_rsp_t t);
      logic [63:0] qx, qy;
      int          x0, y0;
      if (r.op == OP_WARP &&
          map_point(coef_plan, width_reg, height_reg, r.f.ox, r.f.oy, qx, qy)) begin
         x0 = int'(qx >> 16);
         y0 = int'(qy >> 16);
         for (int c = 0; c < CHANNELS; c++)
            for (int dy = 0; dy < 2; dy++)
               for (int dx = 0; dx < 2; dx++)
                  if (!pixel_loaded[pixel_index(c, y0 + dy, x0 + dx)])
                     push_req(mk_sample(8'(x0 + dx), 8'(y0 + dy), 2'(c),
                                        16'($urandom)), '0);
      end
      push_req(r, t);
   endtask

   function automatic logic [31:0] rand_signed(input int span);
      return 32'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic new_homography();
      logic [31:0] k [9];
      k[0] = 32'(int'($urandom_range(0, 131072)) - 32768);
      k[1] = rand_signed(32768);
      k[2] = $urandom_range(0, 4 * 65536);
      k[3] = rand_signed(32768);
      k[4] = 32'(int'($urandom_range(0, 131072)) - 32768);
      k[5] = $urandom_range(0, 4 * 65536);
      k[6] = rand_signed(400);
      k[7] = rand_signed(400);
      k[8] = 32'(65536 + int'(rand_signed(8192)));
      if ($urandom_range(9) == 0)
         foreach (k[i]) k[i] = $urandom;
      foreach (k[i]) send_item(mk_coef(4'(i), k[i]), '0);
   endtask

   task automatic random_item(input logic [8:0] w, input logic [8:0] h);
      int pick;
      pick = $urandom_range(99);
      if (pick < 66)
         send_item(mk_warp(12'($urandom_range(0, 7)), 12'($urandom_range(0, 7))), '0);
      else if (pick < 70)
         new_homography();
      else if (pick < 82)
         send_item(mk_sample(8'($urandom), 8'($urandom), 2'($urandom), 16'($urandom)), '0);
      else if (pick < 86)
         send_item(mk_coef(4'($urandom_range(9, 15)), $urandom), '0);
      else if (pick < 90)
         send_item(mk_coef(4'($urandom_range(0, 8)), $urandom), '0);
      else if (pick < 94)
         send_item('{op: OP_UNUSED, f: req_fields_t'({$urandom, $urandom, $urandom})}, '0);
      else
         send_item(mk_warp(12'($urandom), 12'($urandom)), '0);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sizes(input logic [8:0] w, input logic [8:0] h);
      csr_valid <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_data <= w;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_HEIGHT;
      csr_data <= h;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      width_reg = w;
      height_reg = h;
   endtask

   initial begin
      dir_row_t    dir_tab [$];
      logic [31:0] ident [9];
      logic [8:0]  phase_w [6];
      logic [8:0]  phase_h [6];

      ident = '{32'd65536, 0, 0, 0, 32'd65536, 0, 0, 0, 0};
      foreach (ident[i]) dir_tab.push_back('{mk_coef(4'(i), ident[i]), '0});
      dir_tab.push_back('{mk_warp(3, 3), '{1'b1, 16'd0, 1'b0}});       // zero divisor
      dir_tab.push_back('{mk_coef(8, 32'd65536), '0});
      dir_tab.push_back('{mk_coef(15, 32'hFFFF_FFFF), '0});            // ignored index
      dir_tab.push_back('{'{op: OP_UNUSED, f: '1}, '0});
      dir_tab.push_back('{mk_sample(255, 255, 3, 16'h8000), '0});      // ignored channel
      dir_tab.push_back('{mk_sample(0, 0, 0, 16'h7FFF), '0});
      dir_tab.push_back('{mk_sample(1, 0, 0, 16'h8000), '0});
      dir_tab.push_back('{mk_warp(0, 0), '0});
      dir_tab.push_back('{mk_warp(4095, 4095), '{1'b1, 16'd0, 1'b0}});
      dir_tab.push_back('{mk_warp(254, 254), '0});
      dir_tab.push_back('{mk_warp(255, 3), '{1'b1, 16'd0, 1'b0}});
      dir_tab.push_back('{mk_coef(2, 32'h0000_8000), '0});
      dir_tab.push_back('{mk_warp(0, 0), '0});
      dir_tab.push_back('{mk_coef(0, 32'h8000_0000), '0});
      dir_tab.push_back('{mk_warp(1, 0), '{1'b1, 16'd0, 1'b0}});       // negative position

      phase_w = '{9'd9, 9'd2, 9'd511, 9'd0, 9'd16, 9'd2};
      phase_h = '{9'd13, 9'd2, 9'd300, 9'd1, 9'd256, 9'd2};
      phase_w[5] = $urandom_range(2, 40);
      phase_h[5] = $urandom_range(2, 40);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) send_item(dir_tab[i].req, dir_tab[i].exp);

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         tx_idle_pct = p < 2 ? 37 : (p < 4 ? 56 : 0);
         rx_idle_pct = p < 2 ? 56 : (p < 4 ? 37 : 0);
         write_sizes(phase_w[p], phase_h[p]);
         if (p == 4) hold_cycles = 300;
         new_homography();
         repeat (18) random_item(phase_w[p], phase_h[p]);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("homography_bilinear_warp_test passed");
      else
         $display("homography_bilinear_warp_test failed");
      $finish;
   end

endmodule
